/* rtl/lwc_pkg.sv */
package lwc_pkg;

  // access operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // memory event kinds
  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_WB   = 1'b1;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_SCAN      = 7'b0000010,
    S_DECIDE    = 7'b0000100,
    S_EVICT     = 7'b0001000,
    S_FILL      = 7'b0010000,
    S_FLUSH_RD  = 7'b0100000,
    S_FLUSH_OUT = 7'b1000000
  } state_t;

  // commands from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic step;
  } scan_cmd_t;

  // scan outcome flags from the compare unit
  typedef struct packed {
    logic hit;
    logic free;
  } scan_flags_t;

endpackage

/* rtl/lwc_req_if.sv */
interface lwc_req_if #(
  parameter int ADDR_WIDTH  = 48,
  parameter int STAMP_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             operation;
  logic [ADDR_WIDTH-1:0]  line_address;
  logic [STAMP_WIDTH-1:0] stamp;

  modport source (output valid, operation, line_address, stamp, input ready);
  modport sink (input valid, operation, line_address, stamp, output ready);
endinterface

/* rtl/lwc_evt_if.sv */
interface lwc_evt_if #(
  parameter int ADDR_WIDTH = 48
);
  logic                  valid;
  logic                  ready;
  logic                  event_kind;
  logic [ADDR_WIDTH-1:0] event_address;
  logic                  last;

  modport source (output valid, event_kind, event_address, last, input ready);
  modport sink (input valid, event_kind, event_address, last, output ready);
endinterface

/* rtl/lwc_ram.sv */
module lwc_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lwc_cmp.sv */
module lwc_cmp #(
  parameter int ADDR_WIDTH  = 48,
  parameter int STAMP_WIDTH = 32,
  parameter int WAYS        = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lwc_pkg::scan_cmd_t                   cmd,
  input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] idx,
  input  logic                                 ent_valid,
  input  logic [ADDR_WIDTH-1:0]                ent_addr,
  input  logic [STAMP_WIDTH-1:0]               ent_stamp,
  input  logic [ADDR_WIDTH-1:0]                key_addr,
  output lwc_pkg::scan_flags_t                 flags,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] hit_way,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] free_way,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] min_way,
  output logic [ADDR_WIDTH-1:0]                min_addr
);
  import lwc_pkg::*;

  logic                   min_seen;
  logic [STAMP_WIDTH-1:0] min_stamp;
  logic                   match;
  logic                   older;

  // one tag compare and one stamp compare, applied to one way per step
  assign match = ent_valid && (ent_addr == key_addr);
  assign older = !min_seen || (ent_stamp < min_stamp);

  // running hit, first free way and oldest way
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      flags    <= '0;
      min_seen <= 1'b0;
    end else if (cmd.step) begin
      if (match && !flags.hit) begin
        flags.hit <= 1'b1;
        hit_way   <= idx;
      end
      if (!ent_valid && !flags.free) begin
        flags.free <= 1'b1;
        free_way   <= idx;
      end
      if (ent_valid && older) begin
        min_seen  <= 1'b1;
        min_stamp <= ent_stamp;
        min_way   <= idx;
        min_addr  <= ent_addr;
      end
    end
  end

endmodule

/* rtl/lru_writeback_cache_set_unit.sv */
// Load/store: the ways are scanned in S_SCAN and S_DECIDE makes the hit/miss
// decision; a miss then sends its memory words (writeback of a dirty victim,
// then fill). A new access is taken only once the unit is back in S_IDLE.
// Flush: the ways are read in turn and each valid dirty way is written back.
// The scan uses the single compare unit, which reads one way per cycle from
// the way RAM; a stalled receiver holds the pending word and the sequencer.
// Reset clears all valid and dirty bits; the way RAM is not cleared since an
// entry is only used while its valid bit is set.
module lru_writeback_cache_set_unit #(
  parameter int WAYS        = 8,
  parameter int ADDR_WIDTH  = 48,
  parameter int STAMP_WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  lwc_req_if.sink  access,
  lwc_evt_if.source mem_event
);
  import lwc_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int ENT_W = ADDR_WIDTH + STAMP_WIDTH;

  state_t                 state;
  logic [CNT_W-1:0]       cnt;
  logic                   chk_vld;
  logic [WAY_W-1:0]       chk_idx;
  logic [1:0]             req_op;
  logic [ADDR_WIDTH-1:0]  req_addr;
  logic [STAMP_WIDTH-1:0] req_stamp;
  logic [WAYS-1:0]        way_valid;
  logic [WAYS-1:0]        way_dirty;
  logic [WAYS-1:0]        vd;
  logic [WAYS-1:0]        vd_rest;

  logic                   out_valid;
  logic                   out_kind;
  logic [ADDR_WIDTH-1:0]  out_addr;
  logic                   out_last;

  logic                   acc_fire;
  logic                   slot_free;
  logic                   cnt_end;

  logic                   ram_we;
  logic [WAY_W-1:0]       ram_waddr;
  logic [ENT_W-1:0]       ram_rdata;
  logic [ADDR_WIDTH-1:0]  ent_addr;
  logic [STAMP_WIDTH-1:0] ent_stamp;

  scan_cmd_t              cmd;
  scan_flags_t            flags;
  logic [WAY_W-1:0]       hit_way;
  logic [WAY_W-1:0]       free_way;
  logic [WAY_W-1:0]       min_way;
  logic [WAY_W-1:0]       vict_way;
  logic [ADDR_WIDTH-1:0]  min_addr;

  // handshakes
  assign access.ready = (state == S_IDLE);
  assign acc_fire     = access.valid && access.ready;
  assign slot_free    = !out_valid || mem_event.ready;
  assign cnt_end      = (cnt == CNT_W'(WAYS));

  assign mem_event.valid         = out_valid;
  assign mem_event.event_kind    = out_kind;
  assign mem_event.event_address = out_addr;
  assign mem_event.last          = out_last;

  // dirty lines still to be written back after the current flush way
  assign vd      = way_valid & way_dirty;
  assign vd_rest = (vd >> cnt) >> 1;

  // way RAM holds address and stamp of each way
  assign vict_way  = flags.free ? free_way : min_way;
  assign ram_we    = (state == S_DECIDE);
  assign ram_waddr = flags.hit ? hit_way : vict_way;
  assign ent_addr  = ram_rdata[ENT_W-1 -: ADDR_WIDTH];
  assign ent_stamp = ram_rdata[STAMP_WIDTH-1:0];

  lwc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WAYS)
  ) u_way_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({req_addr, req_stamp}),
    .raddr (cnt[WAY_W-1:0]),
    .rdata (ram_rdata)
  );

  // shared compare unit walks the ways one per cycle
  assign cmd.clear = acc_fire;
  assign cmd.step  = chk_vld;

  lwc_cmp #(
    .ADDR_WIDTH  (ADDR_WIDTH),
    .STAMP_WIDTH (STAMP_WIDTH),
    .WAYS        (WAYS)
  ) u_cmp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .idx       (chk_idx),
    .ent_valid (way_valid[chk_idx]),
    .ent_addr  (ent_addr),
    .ent_stamp (ent_stamp),
    .key_addr  (req_addr),
    .flags     (flags),
    .hit_way   (hit_way),
    .free_way  (free_way),
    .min_way   (min_way),
    .min_addr  (min_addr)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      chk_vld   <= 1'b0;
      way_valid <= '0;
      way_dirty <= '0;
      out_valid <= 1'b0;
    end else begin
      chk_vld <= 1'b0;
      if (out_valid && mem_event.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc_fire) begin
            req_op    <= access.operation;
            req_addr  <= access.line_address;
            req_stamp <= access.stamp;
            cnt       <= '0;
            if (access.operation == OP_FLUSH) begin
              state <= S_FLUSH_RD;
            end else if (access.operation == OP_LOAD || access.operation == OP_STORE) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!cnt_end) begin
            cnt     <= cnt + 1'b1;
            chk_vld <= 1'b1;
            chk_idx <= cnt[WAY_W-1:0];
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (flags.hit) begin
            if (req_op == OP_STORE) begin
              way_dirty[hit_way] <= 1'b1;
            end
            state <= S_IDLE;
          end else begin
            way_valid[vict_way] <= 1'b1;
            way_dirty[vict_way] <= (req_op == OP_STORE);
            if (!flags.free && way_dirty[min_way]) begin
              state <= S_EVICT;
            end else begin
              state <= S_FILL;
            end
          end
        end
        S_EVICT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_WB;
            out_addr  <= min_addr;
            out_last  <= 1'b0;
            state     <= S_FILL;
          end
        end
        S_FILL: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_FILL;
            out_addr  <= req_addr;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_FLUSH_RD: begin
          if (cnt_end) begin
            way_valid <= '0;
            way_dirty <= '0;
            state     <= S_IDLE;
          end else if (vd[cnt[WAY_W-1:0]]) begin
            state <= S_FLUSH_OUT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FLUSH_OUT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_WB;
            out_addr  <= ent_addr;
            out_last  <= (vd_rest == '0);
            cnt       <= cnt + 1'b1;
            state     <= S_FLUSH_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a fill is always the final word of its access
  a_fill_last: assert property (@(posedge clk) disable iff (rst)
    (mem_event.valid && mem_event.event_kind == KIND_FILL) |-> mem_event.last)
    else $error("fill word without last");

  // a hit always points at a valid way
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && flags.hit) |-> way_valid[hit_way])
    else $error("hit on invalid way");

  // eviction only when no free way was found
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT) |-> !flags.free)
    else $error("eviction while a way was free");

  // a finished flush leaves every way invalid
  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH_RD && cnt_end) |=> (way_valid == '0))
    else $error("ways still valid after flush");

endmodule
